### rtl/fan_loop_index_expander_unit_defines.svh
// Assertion macros used by the checker file of the index expander.
`ifndef FAN_LOOP_INDEX_EXPANDER_UNIT_DEFINES_SVH
`define FAN_LOOP_INDEX_EXPANDER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("index expander check failed");

// Consequent must hold in the cycle after the antecedent.
`define FLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("index expander check failed");

`endif

### rtl/fle_pkg.sv
// Types and constants shared by the fan / line-loop index expander.
package fle_pkg;

    localparam int INDEX_W     = 32;
    localparam int MAX_RESULTS = 4;
    localparam int COUNT_W     = 3;
    localparam int POS_W       = 2;

    // Configuration register indexes
    localparam logic CFG_MODE       = 1'b0;
    localparam logic CFG_WIDE_INDEX = 1'b1;

    // Mode codes
    localparam logic MODE_LINE_LOOP = 1'b0;
    localparam logic MODE_TRI_FAN   = 1'b1;

    localparam logic [INDEX_W-1:0] NARROW_MASK = 32'h0000_FFFF;
    localparam logic [INDEX_W-1:0] WIDE_MASK   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [INDEX_W-1:0] index_value;
        logic               last_in;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic mode;
        logic wide_index;
    } cfg_t;

    // One expanded group: up to four indices and how many are used
    typedef struct packed {
        logic [MAX_RESULTS-1:0][INDEX_W-1:0] idx;
        logic [COUNT_W-1:0]                  count;
    } job_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic not_empty;
        job_t head;
    } queue_status_t;

endpackage

### rtl/fle_front.sv
// Front end: accepts index words, tracks the run and builds expansion jobs.
module fle_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  fle_pkg::item_t item,
    input  fle_pkg::cfg_t  cfg,
    input  logic          queue_full,
    output logic          push,
    output fle_pkg::job_t  job
);
    import fle_pkg::*;

    logic [1:0]         run_count_reg, run_count_next;
    logic [INDEX_W-1:0] first_reg, first_next;
    logic [INDEX_W-1:0] prev_reg, prev_next;
    logic [INDEX_W-1:0] mask;
    logic [INDEX_W-1:0] v;
    logic               restart;
    logic               is_fan;
    logic               accept;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign mask       = cfg.wide_index ? WIDE_MASK : NARROW_MASK;
    assign v          = item.index_value & mask;
    assign restart    = (v == mask);
    assign is_fan     = (cfg.mode == MODE_TRI_FAN);
    assign push       = accept && (job.count != '0);

    always_comb
    begin
        job.idx   = '0;
        job.count = '0;
        if (restart)
        begin
            // close the loop on a restart
            if (!is_fan && run_count_reg >= 2'd2)
            begin
                job.idx[0] = prev_reg;
                job.idx[1] = first_reg;
                job.count  = COUNT_W'(2);
            end
        end
        else if (!is_fan)
        begin
            if (run_count_reg != 2'd0)
            begin
                job.idx[0] = prev_reg;
                job.idx[1] = v;
                job.count  = COUNT_W'(2);
                if (item.last_in)
                begin
                    job.idx[2] = v;
                    job.idx[3] = first_reg;
                    job.count  = COUNT_W'(4);
                end
            end
        end
        else if (run_count_reg >= 2'd2)
        begin
            job.idx[0] = first_reg;
            job.idx[1] = prev_reg;
            job.idx[2] = v;
            job.count  = COUNT_W'(3);
        end
    end

    always_comb
    begin
        run_count_next = run_count_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        if (accept)
        begin
            if (!restart)
            begin
                prev_next = v;
                if (run_count_reg == 2'd0)
                begin
                    first_next = v;
                end
            end
            if (restart || item.last_in)
            begin
                run_count_next = 2'd0;
            end
            else if (run_count_reg != 2'd3)
            begin
                run_count_next = run_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= 2'd0;
        end
        else
        begin
            run_count_reg <= run_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        prev_reg  <= prev_next;
    end

endmodule

### rtl/fle_queue.sv
// Two-entry job queue between the front and back ends.
module fle_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fle_pkg::job_t         push_job,
    output logic                  full,
    input  logic                  pop,
    output fle_pkg::queue_status_t status
);
    import fle_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign full             = (fill_reg == 2'd2);
    assign status.not_empty = (fill_reg != 2'd0);
    assign status.head      = entry_reg[rd_ptr_reg];
    assign do_push          = push && !full;
    assign do_pop           = pop && status.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/fle_back.sv
// Back end: walks each job and emits one index word per cycle while result_stall is low.
module fle_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fle_pkg::queue_status_t status,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output fle_pkg::result_t       result
);
    import fle_pkg::*;

    job_t           job_reg, job_next;
    logic           job_valid_reg, job_valid_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic           out_valid_reg, out_valid_next;
    result_t        out_reg, out_next;
    logic           advance;
    logic           finish;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign advance = job_valid_reg && (!out_valid_reg || !result_stall);
    assign finish  = advance && ({1'b0, pos_reg} == (job_reg.count - COUNT_W'(1)));
    assign pop     = status.not_empty && (!job_valid_reg || finish);

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (advance)
        begin
            out_next.out_index   = job_reg.idx[pos_reg];
            out_next.last_result = finish;
            out_valid_next       = 1'b1;
            pos_next             = pos_reg + POS_W'(1);
            if (finish)
            begin
                job_valid_next = 1'b0;
                pos_next       = '0;
            end
        end
        // load the next job when none is held or as soon as the current one hands out its last word
        if (pop)
        begin
            job_next       = status.head;
            job_valid_next = 1'b1;
            pos_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

endmodule

### rtl/fan_loop_index_expander_unit.sv
// Top level of the fan / line-loop to list index expander.
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+--------------------------------------
//  item     | item_valid / item_stall     | item.index_value, item.last_in
//  result   | result_valid / result_stall | result.out_index, result.last_result
//  cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// The front end takes one index word per cycle while the two-entry job queue
// has room; the back end emits one result word per cycle from its output
// register while a job is loaded and result_stall is low. The sustained input
// rate is set by the single output port of the back end, which emits each word
// of a job in turn. The first result word of an item passes the queue entry,
// the back-end job register and its output register. Reset clears run state,
// queue and output; registers return to line loop, 16-bit indices.
module fan_loop_index_expander_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  fle_pkg::item_t   item,
    output logic            result_valid,
    input  logic            result_stall,
    output fle_pkg::result_t result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_index,
    input  logic            cfg_data
);
    import fle_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    logic          queue_full;
    logic          push;
    job_t          job;
    logic          pop;
    queue_status_t status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:       cfg_next.mode       = cfg_data;
                CFG_WIDE_INDEX: cfg_next.wide_index = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .job        (job)
    );

    fle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .full     (queue_full),
        .pop      (pop),
        .status   (status)
    );

    fle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### rtl/fle_checker.sv
// Port-level checks of the index expander and their bind to the top level.
`include "fan_loop_index_expander_unit_defines.svh"

module fle_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input fle_pkg::result_t result,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic             cfg_index,
    input logic             cfg_data
);
    import fle_pkg::*;

    logic       mode_reg;
    logic [2:0] group_pos_reg;
    logic       res_acc;
    logic       res_last;

    assign res_acc  = result_valid && !result_stall;
    assign res_last = res_acc && result.last_result;

    // shadow the mode register and count words within a result group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LINE_LOOP;
            group_pos_reg <= 3'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index == CFG_MODE)
            begin
                mode_reg <= cfg_data;
            end
            if (res_acc)
            begin
                group_pos_reg <= result.last_result ? 3'd0 : group_pos_reg + 3'd1;
            end
        end
    end

    `FLE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
    `FLE_ASSERT_NOW(a_group_max, res_acc && !result.last_result, group_pos_reg < 3'd3)
    `FLE_ASSERT_NOW(a_fan_group, res_last && mode_reg == MODE_TRI_FAN, group_pos_reg == 3'd2)
    `FLE_ASSERT_NOW(a_loop_group, res_last && mode_reg == MODE_LINE_LOOP, group_pos_reg[0])

endmodule

bind fan_loop_index_expander_unit fle_checker u_fle_checker (.*);
